FILE: hw/rtl/dau_pkg.sv
// dau_pkg: shared types and constants of the digamma approximation unit.
// No dependencies; used by the interfaces, dau_recip and the top level.
`timescale 1ns / 1ps

package dau_pkg;

  localparam int ARG_W     = 32;
  localparam int PSI_W     = 32;
  localparam int ACC_W     = 64;
  localparam int ACC_FRAC  = 32;
  localparam int DIV_W     = 33;
  localparam int DIV_BITS  = 2;
  localparam int LN_STEPS  = 32;
  localparam int GRP_SIZE  = 4;
  localparam int IP_W      = 6;

  localparam logic [31:0] LN2_Q32   = 32'd2977044472;
  localparam logic [31:0] C_24_Q32  = 32'(((64'd1 << 32) + 64'd12) / 64'd24);
  localparam logic [31:0] C_960_Q32 = 32'(((64'd7 << 32) + 64'd480) / 64'd960);
  localparam logic [31:0] C_8064_Q32  = 32'(((64'd31 << 32) + 64'd4032) / 64'd8064);
  localparam logic [31:0] C_30720_Q32 = 32'(((64'd127 << 32) + 64'd15360) / 64'd30720);

  localparam logic [63:0] MAG_NEG_MAX = 64'h0000_0000_8000_0000;
  localparam logic [63:0] MAG_POS_MAX = 64'h0000_0000_7fff_ffff;

  typedef struct packed {
    logic vld;
    logic dz;
  } ctl_t;

endpackage

FILE: hw/rtl/dau_if.sv
// dau_in_if / dau_out_if: valid/ready channels of the digamma unit.
// Depends on dau_pkg for the field widths.
`timescale 1ns / 1ps

interface dau_in_if import dau_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ARG_W-1:0] arg_value;

  modport source (output valid, output arg_value, input ready);
  modport sink   (input valid, input arg_value, output ready);
endinterface

interface dau_out_if import dau_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [PSI_W-1:0] psi_value;
  logic                    domain_error;
  logic                    clipped;

  modport source (output valid, output psi_value, output domain_error, output clipped,
                  input ready);
  modport sink   (input valid, input psi_value, input domain_error, input clipped,
                  output ready);
endinterface

FILE: hw/rtl/dau_recip.sv
// dau_recip: pipelined restoring divider giving floor(2^(32+IN_FRAC_BITS) / v).
// Resolves DIV_BITS quotient bits per stage; depends on dau_pkg.
`timescale 1ns / 1ps

module dau_recip import dau_pkg::*; #(
  parameter int IN_FRAC_BITS = 20
) (
  input  logic                      clk,
  input  logic                      en,
  input  logic [DIV_W-1:0]          div_in,
  output logic [33+IN_FRAC_BITS-1:0] quo_out
);

  localparam int QW   = 33 + IN_FRAC_BITS;
  localparam int NS   = (QW + DIV_BITS - 1) / DIV_BITS;
  localparam int NB   = NS * DIV_BITS;
  localparam int LEAD = NB - QW;

  logic [DIV_W-1:0] dv_r     [0:NS-2];
  logic [DIV_W-1:0] rem_r    [0:NS-1];
  logic [NB-1:0]    quo_r    [0:NS-1];
  logic [DIV_W-1:0] dv_in_w  [0:NS-1];
  logic [DIV_W-1:0] rem_in_w [0:NS-1];
  logic [NB-1:0]    quo_in_w [0:NS-1];
  logic [DIV_W-1:0] rem_nxt  [0:NS-1];
  logic [NB-1:0]    quo_nxt  [0:NS-1];

  for (genvar s = 0; s < NS; s++) begin : g_stage
    if (s == 0) begin : g_first
      assign dv_in_w[s]  = div_in;
      assign rem_in_w[s] = '0;
      assign quo_in_w[s] = '0;
    end else begin : g_rest
      assign dv_in_w[s]  = dv_r[s-1];
      assign rem_in_w[s] = rem_r[s-1];
      assign quo_in_w[s] = quo_r[s-1];
    end

    always_comb begin
      logic [DIV_W:0]   t;
      logic [DIV_W-1:0] rem;
      logic [NB-1:0]    q;
      rem = rem_in_w[s];
      q   = quo_in_w[s];
      for (int k = 0; k < DIV_BITS; k++) begin
        t = {rem, ((s * DIV_BITS + k) == LEAD) ? 1'b1 : 1'b0};
        if (t >= {1'b0, dv_in_w[s]}) begin
          rem = DIV_W'(t - {1'b0, dv_in_w[s]});
          q   = {q[NB-2:0], 1'b1};
        end else begin
          rem = t[DIV_W-1:0];
          q   = {q[NB-2:0], 1'b0};
        end
      end
      rem_nxt[s] = rem;
      quo_nxt[s] = q;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s] <= rem_nxt[s];
        quo_r[s] <= quo_nxt[s];
      end
    end

    if (s < NS - 1) begin : g_dv
      always_ff @(posedge clk) begin
        if (en) begin
          dv_r[s] <= dv_in_w[s];
        end
      end
    end
  end

  assign quo_out = quo_r[NS-1][QW-1:0];

endmodule

FILE: hw/rtl/digamma_approx_unit_top.sv
// Digamma approximation unit: one unsigned Q12.20 argument in, signed Q16.16 psi out per
// transfer, with domain-error and saturation flags. One argument is taken every clock while the
// output is not stalled; the longest path is the 32-stage squaring chain of the log unit at the
// defaults, and NS = ceil((33 + IN_FRAC_BITS) / 2) is the depth of each reciprocal divider.
// A stalled output freezes the whole pipeline.
// Depends on dau_pkg, dau_if and dau_recip.
`timescale 1ns / 1ps

module digamma_approx_unit_top import dau_pkg::*; #(
  parameter int RECUR_LIMIT   = 7,
  parameter int IN_FRAC_BITS  = 20,
  parameter int OUT_FRAC_BITS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  dau_in_if.sink    in_ch,
  dau_out_if.source out_ch
);

  localparam int QW      = 33 + IN_FRAC_BITS;
  localparam int NS      = (QW + DIV_BITS - 1) / DIV_BITS;
  localparam int XW      = 34;
  localparam int LN_IDX  = LN_STEPS + 4;
  localparam int SER_IDX = NS + 6;
  localparam int REC_IDX = NS + 3;
  localparam int AL      = ((LN_IDX > SER_IDX) ? LN_IDX : SER_IDX) + 1;
  localparam int LAST    = AL + 3;
  localparam int LN_DL   = AL - LN_IDX;
  localparam int SER_DL  = AL - SER_IDX;
  localparam int REC_DL  = AL - REC_IDX;
  localparam int NG      = (RECUR_LIMIT + GRP_SIZE - 1) / GRP_SIZE;
  localparam int SHIFT   = ACC_FRAC - OUT_FRAC_BITS;

  localparam logic [XW-1:0]    ONE   = XW'(64'd1 << IN_FRAC_BITS);
  localparam logic [XW-1:0]    HALF  = ONE >> 1;
  localparam logic [XW-1:0]    LIMIT = XW'(64'(RECUR_LIMIT) << IN_FRAC_BITS);
  localparam logic [ACC_W-1:0] RND   = ACC_W'(64'd1 << (SHIFT - 1));

  logic en;
  ctl_t ctl_r [0:LAST];
  ctl_t in_ctl;

  assign en          = !ctl_r[LAST].vld || out_ch.ready;
  assign in_ch.ready = en;
  assign in_ctl.vld  = in_ch.valid;
  assign in_ctl.dz   = (in_ch.arg_value == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= LAST; k++) ctl_r[k] <= '0;
    end else if (en) begin
      ctl_r[0] <= in_ctl;
      for (int k = 1; k <= LAST; k++) ctl_r[k] <= ctl_r[k-1];
    end
  end

  // stage 0: argument register
  logic [ARG_W-1:0] x0_r;
  always_ff @(posedge clk) begin
    if (en) x0_r <= in_ch.arg_value;
  end

  // stage 1: recurrence divisors and shifted argument z
  logic [DIV_W-1:0]       dv_nxt [0:RECUR_LIMIT];
  logic [DIV_W-1:0]       dv_r   [0:RECUR_LIMIT];
  logic [RECUR_LIMIT-1:0] act_nxt;
  logic [RECUR_LIMIT-1:0] act_r;

  always_comb begin
    logic [XW-1:0] xv;
    logic [XW-1:0] vj;
    logic [XW-1:0] steps;
    logic [XW-1:0] xf;
    xv = XW'(x0_r);
    for (int j = 0; j < RECUR_LIMIT; j++) begin
      vj         = xv + (XW'(j) << IN_FRAC_BITS);
      act_nxt[j] = (vj < LIMIT);
      dv_nxt[j]  = (act_nxt[j] && x0_r != '0) ? vj[DIV_W-1:0] : DIV_W'(1);
    end
    steps = (xv < LIMIT) ? ((LIMIT - xv + ONE - XW'(1)) >> IN_FRAC_BITS) : '0;
    xf    = xv + (steps << IN_FRAC_BITS);
    dv_nxt[RECUR_LIMIT] = DIV_W'(xf - HALF);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_r  <= dv_nxt;
      act_r <= act_nxt;
    end
  end

  // reciprocal lanes: one per recurrence step, last lane for 1/z
  logic [QW-1:0] quo [0:RECUR_LIMIT];

  for (genvar g = 0; g <= RECUR_LIMIT; g++) begin : g_lane
    dau_recip #(.IN_FRAC_BITS(IN_FRAC_BITS)) u_recip (
      .clk     (clk),
      .en      (en),
      .div_in  (dv_r[g]),
      .quo_out (quo[g])
    );
  end

  logic [RECUR_LIMIT-1:0] actd_r [0:NS-1];
  always_ff @(posedge clk) begin
    if (en) begin
      actd_r[0] <= act_r;
      for (int k = 1; k < NS; k++) actd_r[k] <= actd_r[k-1];
    end
  end

  // log unit: leading-one normalize, then one squaring per stage
  logic [31:0]     m_r    [0:LN_STEPS];
  logic [31:0]     frac_r [0:LN_STEPS];
  logic [IP_W-1:0] ip_r   [0:LN_STEPS];
  logic [31:0]     m_nxt;
  logic [IP_W-1:0] ip_nxt;

  always_comb begin
    logic [IP_W-1:0]  p;
    logic [DIV_W-1:0] z;
    z = dv_r[RECUR_LIMIT];
    p = '0;
    for (int i = 0; i < DIV_W; i++) begin
      if (z[i]) p = IP_W'(i);
    end
    if (p >= IP_W'(31)) m_nxt = 32'(z >> (p - IP_W'(31)));
    else                m_nxt = 32'(z << (IP_W'(31) - p));
    ip_nxt = p - IP_W'(IN_FRAC_BITS);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_r[0]    <= m_nxt;
      frac_r[0] <= '0;
      ip_r[0]   <= ip_nxt;
    end
  end

  logic [63:0] sq_w [1:LN_STEPS];
  for (genvar k = 1; k <= LN_STEPS; k++) begin : g_sq
    assign sq_w[k] = 64'(m_r[k-1]) * 64'(m_r[k-1]);
    always_ff @(posedge clk) begin
      if (en) begin
        ip_r[k] <= ip_r[k-1];
        if (sq_w[k][63]) begin
          m_r[k]    <= sq_w[k][63:32];
          frac_r[k] <= {frac_r[k-1][30:0], 1'b1};
        end else begin
          m_r[k]    <= sq_w[k][62:31];
          frac_r[k] <= {frac_r[k-1][30:0], 1'b0};
        end
      end
    end
  end

  logic [63:0]      lnf_w;
  logic [31:0]      lnf_r;
  logic [37:0]      lni_r;
  logic [ACC_W-1:0] ln_r;

  assign lnf_w = 64'(frac_r[LN_STEPS]) * 64'(LN2_Q32);

  always_ff @(posedge clk) begin
    if (en) begin
      lnf_r <= lnf_w[63:32];
      lni_r <= 38'(ip_r[LN_STEPS]) * 38'(LN2_Q32);
      ln_r  <= ACC_W'(lni_r) + ACC_W'(lnf_r);
    end
  end

  // even-power series on r = 1/z
  logic [31:0] rz;
  logic [63:0] r2_w, r4_w, r6_w, r8_w, t2_w, t4_w, t6_w, t8_w;
  logic [31:0] r2_r, r4_r, r2b_r, r6_r, r8_r, r2c_r, r4c_r;
  logic [31:0] t2_r, t4_r, t6_r, t8_r;
  logic [ACC_W-1:0] ser_r;

  assign rz   = quo[RECUR_LIMIT][31:0];
  assign r2_w = 64'(rz) * 64'(rz);
  assign r4_w = 64'(r2_r) * 64'(r2_r);
  assign r6_w = 64'(r4_r) * 64'(r2b_r);
  assign r8_w = 64'(r4_r) * 64'(r4_r);
  assign t2_w = 64'(C_24_Q32) * 64'(r2c_r);
  assign t4_w = 64'(C_960_Q32) * 64'(r4c_r);
  assign t6_w = 64'(C_8064_Q32) * 64'(r6_r);
  assign t8_w = 64'(C_30720_Q32) * 64'(r8_r);

  always_ff @(posedge clk) begin
    if (en) begin
      r2_r  <= r2_w[63:32];
      r4_r  <= r4_w[63:32];
      r2b_r <= r2_r;
      r6_r  <= r6_w[63:32];
      r8_r  <= r8_w[63:32];
      r2c_r <= r2b_r;
      r4c_r <= r4_r;
      t2_r  <= t2_w[63:32];
      t4_r  <= t4_w[63:32];
      t6_r  <= t6_w[63:32];
      t8_r  <= t8_w[63:32];
      ser_r <= ACC_W'(t2_r) - ACC_W'(t4_r) + ACC_W'(t6_r) - ACC_W'(t8_r);
    end
  end

  // recurrence sum: groups, then total
  logic [ACC_W-1:0] grp_nxt [0:NG-1];
  logic [ACC_W-1:0] grp_r   [0:NG-1];
  logic [ACC_W-1:0] rec_nxt;
  logic [ACC_W-1:0] rec_r;

  always_comb begin
    for (int g = 0; g < NG; g++) begin
      grp_nxt[g] = '0;
      for (int k = 0; k < GRP_SIZE; k++) begin
        if ((g * GRP_SIZE + k) < RECUR_LIMIT) begin
          if (actd_r[NS-1][g * GRP_SIZE + k]) begin
            grp_nxt[g] = grp_nxt[g] + ACC_W'(quo[g * GRP_SIZE + k]);
          end
        end
      end
    end
    rec_nxt = '0;
    for (int g = 0; g < NG; g++) rec_nxt = rec_nxt + grp_r[g];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      grp_r <= grp_nxt;
      rec_r <= rec_nxt;
    end
  end

  // alignment lines
  logic [ACC_W-1:0] lnd_r  [0:LN_DL-1];
  logic [ACC_W-1:0] serd_r [0:SER_DL-1];
  logic [ACC_W-1:0] recd_r [0:REC_DL-1];

  always_ff @(posedge clk) begin
    if (en) begin
      lnd_r[0]  <= ln_r;
      serd_r[0] <= ser_r;
      recd_r[0] <= rec_r;
      for (int k = 1; k < LN_DL; k++)  lnd_r[k]  <= lnd_r[k-1];
      for (int k = 1; k < SER_DL; k++) serd_r[k] <= serd_r[k-1];
      for (int k = 1; k < REC_DL; k++) recd_r[k] <= recd_r[k-1];
    end
  end

  // accumulate, round, saturate
  logic [ACC_W-1:0] acc_r;
  logic [ACC_W-1:0] abs_w;
  logic [ACC_W-1:0] mag_r;
  logic             neg_r;
  logic [PSI_W-1:0] psi_r, psi_nxt;
  logic             clip_r, clip_nxt;

  assign abs_w = acc_r[ACC_W-1] ? (~acc_r + ACC_W'(1)) : acc_r;

  always_comb begin
    psi_nxt  = '0;
    clip_nxt = 1'b0;
    if (ctl_r[LAST-1].dz) begin
      psi_nxt  = '0;
      clip_nxt = 1'b0;
    end else if (neg_r) begin
      clip_nxt = (mag_r > MAG_NEG_MAX);
      psi_nxt  = clip_nxt ? PSI_W'(32'h8000_0000) : PSI_W'(~mag_r + ACC_W'(1));
    end else begin
      clip_nxt = (mag_r > MAG_POS_MAX);
      psi_nxt  = clip_nxt ? PSI_W'(MAG_POS_MAX) : PSI_W'(mag_r);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      acc_r  <= lnd_r[LN_DL-1] + serd_r[SER_DL-1] - recd_r[REC_DL-1];
      neg_r  <= acc_r[ACC_W-1];
      mag_r  <= (abs_w + RND) >> SHIFT;
      psi_r  <= psi_nxt;
      clip_r <= clip_nxt;
    end
  end

  assign out_ch.valid        = ctl_r[LAST].vld;
  assign out_ch.psi_value    = psi_r;
  assign out_ch.domain_error = ctl_r[LAST].dz;
  assign out_ch.clipped      = clip_r;

  a_dz_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.domain_error |-> out_ch.psi_value == '0 && !out_ch.clipped)
    else $error("domain error result not zero");

  a_clip_extreme: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.clipped |->
      psi_r == PSI_W'(32'h8000_0000) || psi_r == PSI_W'(MAG_POS_MAX))
    else $error("clipped result not at range limit");

  a_entry: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> ctl_r[0].vld)
    else $error("transfer did not enter pipeline");

  a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(psi_r) && $stable(ctl_r[LAST-1]))
    else $error("pipeline moved while stalled");

endmodule
